>>> hdl/adc_pkg.sv
// Shared types and constants for the automatic door mode controller.
// No dependencies; used by adc_step, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package adc_pkg;

    // Door phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_BLINK   = 5'b00010,
        PH_OPENING = 5'b00100,
        PH_HOLDING = 5'b01000,
        PH_CLOSING = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] timer;
        logic        first_pending;
    } t_state;

    // drive word codes: bit0 open, bit1 close, bit2 lamp
    localparam logic [2:0] DRIVE_OFF   = 3'd0;
    localparam logic [2:0] DRIVE_LAMP  = 3'd4;
    localparam logic [2:0] DRIVE_OPEN  = 3'd5;
    localparam logic [2:0] DRIVE_CLOSE = 3'd6;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_REPAIR = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;
    localparam logic [1:0] MODE_AUTO   = 2'd3;

    // configuration register indexes
    localparam logic CFG_HOLD_OPEN = 1'b0;
    localparam logic CFG_BLINK     = 1'b1;

    localparam logic [15:0] HOLD_OPEN_RESET = 16'd150;
    localparam logic [15:0] BLINK_RESET     = 16'd250;

    // sensor_port_low bit positions
    localparam int LO_SW1      = 0;
    localparam int LO_SW2      = 1;
    localparam int LO_OPEN_BTN = 2;
    localparam int LO_CLOSE_BTN = 3;
    localparam int LO_OPEN_END = 4;
    localparam int LO_CLOSED_END = 6;
    localparam int LO_REAR_LB  = 7;
    // sensor_port_high bit positions
    localparam int HI_FRONT_LB = 0;
    localparam int HI_MOTION   = 1;

endpackage

`default_nettype wire

>>> hdl/adc_step.sv
// One tick of the door controller: next state, drive word and mode.
// Pure combinational; uses adc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adc_step (
    input  wire logic [7:0]      i_lo,
    input  wire logic [2:0]      i_hi,
    input  wire logic [15:0]     i_hold_ticks,
    input  wire logic [15:0]     i_blink_ticks,
    input  wire adc_pkg::t_state i_state,
    output adc_pkg::t_state      o_state,
    output logic [2:0]           o_drive,
    output logic [1:0]           o_mode
);

    logic sw1, sw2, open_btn, close_btn, open_end, closed_end;
    logic presence, demand, close_ok;

    assign sw1        = i_lo[adc_pkg::LO_SW1];
    assign sw2        = i_lo[adc_pkg::LO_SW2];
    assign open_btn   = i_lo[adc_pkg::LO_OPEN_BTN];
    assign close_btn  = i_lo[adc_pkg::LO_CLOSE_BTN];
    assign open_end   = i_lo[adc_pkg::LO_OPEN_END];
    assign closed_end = i_lo[adc_pkg::LO_CLOSED_END];
    assign presence   = i_lo[adc_pkg::LO_REAR_LB] | i_hi[adc_pkg::HI_FRONT_LB]
                      | i_hi[adc_pkg::HI_MOTION];
    assign demand     = presence | open_btn;
    // close button overrides demand, never past the closed end
    assign close_ok   = !closed_end && (!demand || close_btn);
    assign o_mode     = {sw1, sw2};

    always_comb begin
        adc_pkg::t_phase ph;
        logic [15:0]     tm;
        logic            fp;
        logic            done;
        logic [2:0]      drv;

        ph   = i_state.phase;
        tm   = i_state.timer;
        fp   = i_state.first_pending;
        done = 1'b0;
        drv  = adc_pkg::DRIVE_OFF;

        if (o_mode == adc_pkg::MODE_AUTO) begin
            if (fp) begin
                fp = 1'b0;
                ph = adc_pkg::PH_BLINK;
                tm = i_blink_ticks;
            end
            if (ph == adc_pkg::PH_BLINK) begin
                if (tm != 16'd0) begin
                    tm   = tm - 16'd1;
                    drv  = adc_pkg::DRIVE_LAMP;
                    done = 1'b1;
                end else begin
                    ph = adc_pkg::PH_IDLE;
                end
            end
            if (!done && ph == adc_pkg::PH_OPENING) begin
                if (!open_end) begin
                    drv  = adc_pkg::DRIVE_OPEN;
                    done = 1'b1;
                end else begin
                    ph = adc_pkg::PH_HOLDING;
                    tm = i_hold_ticks;
                end
            end
            if (!done && ph == adc_pkg::PH_HOLDING) begin
                if (tm != 16'd0) begin
                    tm   = tm - 16'd1;
                    done = 1'b1;
                end else begin
                    ph = adc_pkg::PH_IDLE;
                end
            end
            if (!done && ph == adc_pkg::PH_CLOSING) begin
                done = 1'b1;
                if (close_ok) begin
                    drv = adc_pkg::DRIVE_CLOSE;
                end else begin
                    ph = adc_pkg::PH_IDLE;
                end
            end
            // idle, or any code that is not a single phase
            if (!done) begin
                ph = adc_pkg::PH_IDLE;
                tm = 16'd0;
                if (open_end) begin
                    if (close_ok) begin
                        ph  = adc_pkg::PH_CLOSING;
                        drv = adc_pkg::DRIVE_CLOSE;
                    end
                end else if (demand) begin
                    ph  = adc_pkg::PH_OPENING;
                    drv = adc_pkg::DRIVE_OPEN;
                end
            end
        end else begin
            ph = adc_pkg::PH_IDLE;
            tm = 16'd0;
            if (o_mode == adc_pkg::MODE_REPAIR) begin
                if (!open_end && demand) begin
                    drv = adc_pkg::DRIVE_OPEN;
                end else if (close_btn && !closed_end) begin
                    drv = adc_pkg::DRIVE_CLOSE;
                end
            end else if (o_mode == adc_pkg::MODE_MANUAL) begin
                if (open_btn && !close_btn && !open_end) begin
                    drv = adc_pkg::DRIVE_OPEN;
                end else if (close_btn && !open_btn && !closed_end) begin
                    drv = adc_pkg::DRIVE_CLOSE;
                end
            end
        end

        o_state.phase         = ph;
        o_state.timer         = tm;
        o_state.first_pending = fp;
        o_drive               = drv;
    end

endmodule

`default_nettype wire

>>> hdl/automatic_door_mode_controller.sv
// Top level of the automatic door mode controller: handshakes, registers, config.
// Depends on adc_pkg and adc_step.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - Input channel: one beat per sensor tick (i_sensor_port_low/high) on
//    i_in_valid, held off by o_in_stall.
//  - Output channel: one beat per input beat (o_drive_word, o_mode) on
//    o_out_valid, held off by i_out_stall.
//  - Pipeline: two register stages; the input register loads at the accepting
//    edge and the tick logic moves the beat into the result register as soon
//    as that register is empty or not held by i_out_stall.
//  - Throughput: one beat per cycle while the output is not stalled; the door state is updated as each beat
//    moves from the input register into the result register, so beats may
//    follow back to back.
//  - A stall on the output holds the result register; the input register
//    still takes one more beat, after which o_in_stall rises until the
//    output drains.
//  - Config: i_cfg_we with i_cfg_index (0 hold-open ticks, 1 start-up lamp
//    ticks) and 16-bit i_cfg_data; write only while no beats are in flight.
//  - Reset (synchronous, i_rst_n low): both stages empty, door phase idle,
//    timer zero, start-up lamp owed, hold 150 and lamp 250 ticks.
module automatic_door_mode_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_sensor_port_low,
    input  wire logic [2:0]  i_sensor_port_high,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_drive_word,
    output logic [1:0]       o_mode,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // input register
    logic            r_s1_valid;
    logic [7:0]      r_s1_lo;
    logic [2:0]      r_s1_hi;
    // result register
    logic            r_out_valid;
    logic [2:0]      r_drive;
    logic [1:0]      r_mode;
    // door state and config
    adc_pkg::t_state r_state;
    logic [15:0]     r_hold_ticks;
    logic [15:0]     r_blink_ticks;

    adc_pkg::t_state n_state;
    logic [2:0]      n_drive;
    logic [1:0]      n_mode;

    logic out_free;   // result register can take a beat this cycle
    logic advance;    // input register moves into the result register
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    adc_step u_step (
        .i_lo          (r_s1_lo),
        .i_hi          (r_s1_hi),
        .i_hold_ticks  (r_hold_ticks),
        .i_blink_ticks (r_blink_ticks),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_drive       (n_drive),
        .o_mode        (n_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_lo <= i_sensor_port_low;
            r_s1_hi <= i_sensor_port_high;
        end
        if (advance) begin
            r_drive <= n_drive;
            r_mode  <= n_mode;
        end
    end

    // door state steps once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= adc_pkg::PH_IDLE;
            r_state.timer         <= 16'd0;
            r_state.first_pending <= 1'b1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks  <= adc_pkg::HOLD_OPEN_RESET;
            r_blink_ticks <= adc_pkg::BLINK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                adc_pkg::CFG_HOLD_OPEN: r_hold_ticks  <= i_cfg_data;
                adc_pkg::CFG_BLINK:     r_blink_ticks <= i_cfg_data;
                default:                ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive_word = r_drive;
    assign o_mode       = r_mode;

endmodule

`default_nettype wire

>>> hdl/adc_checker.sv
// Port-level checks for the automatic door mode controller, bound to the top.
// Depends on adc_pkg and automatic_door_mode_controller.
`timescale 1ns / 1ps
`default_nettype none

module adc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [2:0] o_drive_word,
    input wire logic [1:0] o_mode
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_drive_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_word == adc_pkg::DRIVE_OFF
                      || o_drive_word == adc_pkg::DRIVE_LAMP
                      || o_drive_word == adc_pkg::DRIVE_OPEN
                      || o_drive_word == adc_pkg::DRIVE_CLOSE))
        else $error("illegal drive word");

    a_off_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode == adc_pkg::MODE_OFF) |-> o_drive_word == adc_pkg::DRIVE_OFF)
        else $error("motor or lamp driven in off mode");

    a_lamp_auto_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_word == adc_pkg::DRIVE_LAMP) |-> o_mode == adc_pkg::MODE_AUTO)
        else $error("start-up lamp outside automatic mode");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_drive_word) && $stable(o_mode)))
        else $error("stalled result changed");

endmodule

bind automatic_door_mode_controller adc_checker u_adc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_drive_word (o_drive_word),
    .o_mode       (o_mode)
);

`default_nettype wire

>>> verif/automatic_door_mode_controller_tb.sv
// Self-checking bench for automatic_door_mode_controller: sensor ticks in, drive/mode beats
// checked against a door model kept in this file. Depends on adc_pkg and the top level RTL.
`timescale 1ns / 1ps
module automatic_door_mode_controller_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_PHASE  = 2;
    localparam int NUM_PHASES      = 5;
    localparam int TICKS_PER_PHASE = 200;

    typedef struct packed {
        logic [7:0] lo;
        logic [2:0] hi;
    } t_sample;

    typedef struct packed {
        logic [2:0] drive;
        logic [1:0] mode;
    } t_outputs;

    // bench signals; all that the bench drives are known from time zero
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    t_sample     in_sample   = '0;
    logic        out_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    logic        cfg_index   = adc_pkg::CFG_HOLD_OPEN;
    logic [15:0] cfg_data    = '0;
    logic        hold_kick   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  drive_word;
    logic [1:0]  mode;

    logic [3:0]  in_wait     = '0;
    logic [3:0]  out_wait    = '0;
    int          hold_left   = 0;
    int          in_gap_max  = 0;
    int          out_gap_max = 0;
    int          faults      = 0;
    int          cycles      = 0;

    t_sample     ticks_pending [$];
    t_outputs    outputs_due   [$];

    // door model state and its copy of the registers
    adc_pkg::t_phase door_ph     = adc_pkg::PH_IDLE;
    logic [15:0]     ph_timer    = '0;
    logic            blink_owed  = 1'b1;
    logic [15:0]     hold_ticks  = adc_pkg::HOLD_OPEN_RESET;
    logic [15:0]     blink_ticks = adc_pkg::BLINK_RESET;

    automatic_door_mode_controller u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_sensor_port_low  (in_sample.lo),
        .i_sensor_port_high (in_sample.hi),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_drive_word       (drive_word),
        .o_mode             (mode),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // Automatic mode: lamp once on first entry, then open on demand, hold,
    // close unless something is in the way. Phases fall through in one tick.
    function automatic logic [2:0] auto_drive(input logic demand, input logic close_btn,
                                              input logic open_end, input logic closed_end);
        logic close_ok;
        close_ok = !closed_end && (!demand || close_btn);
        if (blink_owed) begin
            blink_owed = 1'b0;
            door_ph    = adc_pkg::PH_BLINK;
            ph_timer   = blink_ticks;
        end
        if (door_ph == adc_pkg::PH_BLINK) begin
            if (ph_timer != 0) begin
                ph_timer = ph_timer - 1'b1;
                return adc_pkg::DRIVE_LAMP;
            end
            door_ph = adc_pkg::PH_IDLE;
        end
        if (door_ph == adc_pkg::PH_OPENING) begin
            if (!open_end)
                return adc_pkg::DRIVE_OPEN;
            door_ph  = adc_pkg::PH_HOLDING;
            ph_timer = hold_ticks;
        end
        if (door_ph == adc_pkg::PH_HOLDING) begin
            if (ph_timer != 0) begin
                ph_timer = ph_timer - 1'b1;
                return adc_pkg::DRIVE_OFF;
            end
            door_ph = adc_pkg::PH_IDLE;  // hold over: idle logic decides from here
        end
        if (door_ph == adc_pkg::PH_CLOSING) begin
            if (close_ok)
                return adc_pkg::DRIVE_CLOSE;
            door_ph = adc_pkg::PH_IDLE;
            return adc_pkg::DRIVE_OFF;
        end
        door_ph  = adc_pkg::PH_IDLE;
        ph_timer = '0;
        // door found open without an opening phase closes straight away
        if (open_end) begin
            if (close_ok) begin
                door_ph = adc_pkg::PH_CLOSING;
                return adc_pkg::DRIVE_CLOSE;
            end
            return adc_pkg::DRIVE_OFF;
        end
        if (demand) begin
            door_ph = adc_pkg::PH_OPENING;
            return adc_pkg::DRIVE_OPEN;
        end
        return adc_pkg::DRIVE_OFF;
    endfunction

    // One sensor tick through the door model; spare bits play no part.
    function automatic t_outputs door_tick(input t_sample s);
        t_outputs r;
        logic     presence;
        logic     open_btn;
        logic     close_btn;
        logic     open_end;
        logic     closed_end;
        open_btn   = s.lo[adc_pkg::LO_OPEN_BTN];
        close_btn  = s.lo[adc_pkg::LO_CLOSE_BTN];
        open_end   = s.lo[adc_pkg::LO_OPEN_END];
        closed_end = s.lo[adc_pkg::LO_CLOSED_END];
        presence   = s.lo[adc_pkg::LO_REAR_LB] | s.hi[adc_pkg::HI_FRONT_LB]
                   | s.hi[adc_pkg::HI_MOTION];
        r.mode     = {s.lo[adc_pkg::LO_SW1], s.lo[adc_pkg::LO_SW2]};
        r.drive    = adc_pkg::DRIVE_OFF;
        if (r.mode == adc_pkg::MODE_AUTO) begin
            r.drive = auto_drive(presence | open_btn, close_btn, open_end, closed_end);
        end else begin
            // any other mode drops the automatic sequence, lamp flag left as it is
            door_ph  = adc_pkg::PH_IDLE;
            ph_timer = '0;
            if (r.mode == adc_pkg::MODE_REPAIR) begin
                if (!open_end && (presence || open_btn))
                    r.drive = adc_pkg::DRIVE_OPEN;
                else if (close_btn && !closed_end)
                    r.drive = adc_pkg::DRIVE_CLOSE;
            end else if (r.mode == adc_pkg::MODE_MANUAL) begin
                // both buttons held: motor stays off
                if (open_btn && !close_btn && !open_end)
                    r.drive = adc_pkg::DRIVE_OPEN;
                else if (close_btn && !open_btn && !closed_end)
                    r.drive = adc_pkg::DRIVE_CLOSE;
            end
        end
        return r;
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic report_fault(input string what, input int want, input int got);
        if (faults < 10)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        faults++;
    endtask

    // Input side: one beat per queued tick, random gap after each.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_wait  <= '0;
        end else begin
            if (in_valid && !in_stall)
                outputs_due.push_back(door_tick(in_sample));
            if (!in_valid || !in_stall) begin
                if (in_wait != 0) begin
                    in_wait  <= in_wait - 1'b1;
                    in_valid <= 1'b0;
                end else if (ticks_pending.size() != 0) begin
                    in_sample <= ticks_pending.pop_front();
                    in_valid  <= 1'b1;
                    in_wait   <= 4'($urandom_range(0, in_gap_max));
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted beat, then stall for a random count.
    always @(posedge clk) begin : result_side
        t_outputs   want;
        logic [3:0] wait_next;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_wait  <= '0;
        end else begin
            wait_next = (out_wait != 0) ? out_wait - 1'b1 : 4'd0;
            if (out_valid && !out_stall) begin
                wait_next = 4'($urandom_range(0, out_gap_max));
                if (outputs_due.size() == 0) begin
                    report_fault("result beat with nothing outstanding", -1, drive_word);
                end else begin
                    want = outputs_due.pop_front();
                    if (want.drive !== drive_word)
                        report_fault("drive_word", want.drive, drive_word);
                    if (want.mode !== mode)
                        report_fault("mode", want.mode, mode);
                end
            end
            out_wait  <= wait_next;
            out_stall <= (wait_next != 0) || (hold_left != 0);
        end
    end

    // Long receiver hold-off, so both pipeline stages fill and the input stalls.
    always @(posedge clk) begin
        if (hold_kick)
            hold_left <= HOLD_OFF_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("automatic_door_mode_controller regression: fail");
            $finish;
        end
    end

    task automatic queue_tick(input logic [7:0] lo, input logic [2:0] hi);
        t_sample s;
        s.lo = lo;
        s.hi = hi;
        ticks_pending.push_back(s);
    endtask

    // Runs of one mode, mostly automatic, with plausible sensor odds; a few
    // ticks are pure noise.
    task automatic queue_random_ticks(input int count);
        t_sample    s;
        logic [1:0] run_mode;
        int         run_left;
        run_left = 0;
        run_mode = adc_pkg::MODE_OFF;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                run_mode = chance(60) ? adc_pkg::MODE_AUTO : 2'($urandom_range(0, 2));
                run_left = $urandom_range(1, 40);
            end
            run_left--;
            s.lo = 8'($urandom);
            s.hi = 3'($urandom);
            if (!chance(5)) begin
                s.lo[adc_pkg::LO_SW1]        = run_mode[1];
                s.lo[adc_pkg::LO_SW2]        = run_mode[0];
                s.lo[adc_pkg::LO_OPEN_BTN]   = chance(15);
                s.lo[adc_pkg::LO_CLOSE_BTN]  = chance(10);
                s.lo[adc_pkg::LO_OPEN_END]   = chance(30);
                s.lo[adc_pkg::LO_CLOSED_END] = chance(25);
                s.lo[adc_pkg::LO_REAR_LB]    = chance(12);
                s.hi[adc_pkg::HI_FRONT_LB]   = chance(12);
                s.hi[adc_pkg::HI_MOTION]     = chance(12);
            end
            ticks_pending.push_back(s);
        end
    endtask

    // Nothing queued, nothing on the wire, nothing owed; then a few spare cycles.
    task automatic settle();
        do
            @(negedge clk);
        while (ticks_pending.size() != 0 || in_valid || outputs_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input logic [15:0] hold, input logic [15:0] blink);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= adc_pkg::CFG_HOLD_OPEN;
        cfg_data  <= hold;
        @(posedge clk);
        cfg_index <= adc_pkg::CFG_BLINK;
        cfg_data  <= blink;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_ticks  = hold;
        blink_ticks = blink;
    endtask

    initial begin : stimulus
        logic [15:0] hold_by_phase  [NUM_PHASES];
        logic [15:0] blink_by_phase [NUM_PHASES];
        int          in_gap_by_phase  [NUM_PHASES];
        int          out_gap_by_phase [NUM_PHASES];

        hold_by_phase[0]  = 16'd5;      blink_by_phase[0]  = 16'd0;
        hold_by_phase[1]  = 16'hFFFF;   blink_by_phase[1]  = 16'hFFFF;
        hold_by_phase[2]  = 16'd20;     blink_by_phase[2]  = 16'd20;
        hold_by_phase[3]  = 16'($urandom_range(0, 40));
        blink_by_phase[3] = 16'($urandom);
        hold_by_phase[4]  = 16'd1;      blink_by_phase[4]  = 16'd7;
        in_gap_by_phase[0]  = 0;  out_gap_by_phase[0] = 0;
        in_gap_by_phase[1]  = 15; out_gap_by_phase[1] = 15;
        in_gap_by_phase[2]  = 0;  out_gap_by_phase[2] = 3;
        in_gap_by_phase[3]  = 3;  out_gap_by_phase[3] = 15;
        in_gap_by_phase[4]  = 15; out_gap_by_phase[4] = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero hold so an open door turns straight round; short lamp on entry
        set_registers(16'd0, 16'd3);
        in_gap_max  = 2;
        out_gap_max = 2;
        queue_tick(8'h00, 3'h0);    // off, all quiet
        queue_tick(8'hFC, 3'h7);    // off, every other sensor set
        queue_tick(8'h02, 3'h1);    // repair, front barrier opens
        queue_tick(8'h12, 3'h2);    // repair, motion but already open
        queue_tick(8'h0A, 3'h0);    // repair close
        queue_tick(8'h4A, 3'h0);    // repair close at closed end
        queue_tick(8'hA2, 3'h0);    // repair, rear barrier, spare bit
        queue_tick(8'h05, 3'h0);    // manual open
        queue_tick(8'h09, 3'h0);    // manual close
        queue_tick(8'h0D, 3'h0);    // manual, both buttons
        queue_tick(8'h15, 3'h0);    // manual open at open end
        queue_tick(8'h49, 3'h0);    // manual close at closed end
        queue_tick(8'h03, 3'h0);    // automatic entry: lamp for three ticks
        queue_tick(8'h03, 3'h0);
        queue_tick(8'h03, 3'h0);
        queue_tick(8'h03, 3'h0);    // lamp done, idle
        queue_tick(8'h07, 3'h0);    // open button starts opening
        queue_tick(8'h03, 3'h4);    // still opening, spare high bit
        queue_tick(8'h13, 3'h0);    // open end, zero hold, closes same tick
        queue_tick(8'h03, 3'h1);    // barrier stops the closing
        queue_tick(8'h03, 3'h1);    // demand opens again
        queue_tick(8'h01, 3'h0);    // leaving automatic mid-opening
        queue_tick(8'h13, 3'h0);    // back in automatic, found open: close
        queue_tick(8'h1F, 3'h1);    // close button overrides demand
        queue_tick(8'h4B, 3'h0);    // close button stops at closed end
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_registers(hold_by_phase[p], blink_by_phase[p]);
            in_gap_max  = in_gap_by_phase[p];
            out_gap_max = out_gap_by_phase[p];
            queue_random_ticks(TICKS_PER_PHASE);
            if (p == PRESSURE_PHASE) begin
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            settle();
        end

        repeat (10) @(posedge clk);
        if (faults == 0 && outputs_due.size() == 0)
            $display("automatic_door_mode_controller regression: pass");
        else
            $display("automatic_door_mode_controller regression: fail");
        $finish;
    end

endmodule
